/* hdl/stxma_pkg.sv */
// Shared types and constants for the STUN XOR-MAPPED-ADDRESS parser.
package stxma_pkg;

  localparam logic [15:0] BINDING_RESPONSE = 16'h0101;
  localparam logic [15:0] XOR_ADDR_ATTR    = 16'h0020;
  localparam logic [31:0] XOR_COOKIE       = 32'h2112A442;
  localparam logic [15:0] PORT_MASK        = XOR_COOKIE[31:16];

  localparam logic [16:0] ATTR_HDR_BYTES = 17'd4;
  localparam logic [16:0] ADDR_BYTES     = 17'd8;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ATTR_HDR = 3'd1,
    PH_SKIP     = 3'd2,
    PH_ADDR     = 3'd3,
    PH_DONE     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_NO_ADDR  = 2'd2
  } status_e;

  // One byte leaving the input register towards the parser
  typedef struct packed {
    logic       fire;
    logic [7:0] data_byte;
    logic       last_byte;
  } step_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] public_address;
    logic [15:0] mapped_port;
  } result_t;

endpackage

/* hdl/stxma_in_if.sv */
// Byte input channel: valid/ready handshake with datagram byte and end mark.
interface stxma_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
  modport monitor (input valid, input data_byte, input last_byte, input ready);
endinterface

/* hdl/stxma_out_if.sv */
// Result channel: valid/ready handshake with status, address and port.
interface stxma_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] public_address;
  logic [15:0] mapped_port;

  modport source (output valid, output status, output public_address,
                  output mapped_port, input ready);
  modport sink (input valid, input status, input public_address,
                input mapped_port, output ready);
  modport monitor (input valid, input status, input public_address,
                   input mapped_port, input ready);
endinterface

/* hdl/stxma_in_stage.sv */
// Input register: holds one byte until the parser can take it.
module stxma_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  stxma_in_if.sink           in_i,
  input  logic               out_free_i,
  output stxma_pkg::step_t   step_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       advance;

  // A final byte needs a free result slot; other bytes always move on
  assign advance    = valid_q && (!last_q || out_free_i);
  assign in_i.ready = !valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  assign step_o.fire      = advance;
  assign step_o.data_byte = data_q;
  assign step_o.last_byte = last_q;

endmodule

/* hdl/stxma_parser.sv */
// Per-byte parse state and the result decoded at the final byte.
module stxma_parser #(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stxma_pkg::step_t     step_i,
  output stxma_pkg::result_t   result_o
);

  localparam int unsigned IdxW = $clog2(MAX_BYTES + 1);

  logic [IdxW-1:0]   idx_q, idx_d;
  stxma_pkg::phase_e phase_q, phase_d;
  logic              match_q, match_d;
  logic [15:0]       atype_q, atype_d;
  logic [15:0]       alen_q, alen_d;
  logic [16:0]       rem_q, rem_d;
  logic [15:0]       port_q, port_d;
  logic [31:0]       addr_q, addr_d;
  logic              found_q, found_d;

  always_comb begin
    logic [16:0] padded;
    logic [15:0] merged;

    idx_d   = idx_q;
    phase_d = phase_q;
    match_d = match_q;
    atype_d = atype_q;
    alen_d  = alen_q;
    rem_d   = rem_q;
    port_d  = port_q;
    addr_d  = addr_q;
    found_d = found_q;
    padded  = '0;
    merged  = '0;

    result_o.status         = stxma_pkg::ST_NO_ADDR;
    result_o.public_address = '0;
    result_o.mapped_port    = '0;

    // Bytes past the receive limit are dropped, but the end mark still counts
    if (idx_q < IdxW'(MAX_BYTES)) begin
      idx_d = idx_q + IdxW'(1);
      unique case (phase_q)
        stxma_pkg::PH_HEADER: begin
          if (idx_q == IdxW'(0)) begin
            atype_d = {8'h00, step_i.data_byte};
          end else if (idx_q == IdxW'(1)) begin
            merged  = {atype_q[7:0], step_i.data_byte};
            atype_d = merged;
            match_d = (merged == stxma_pkg::BINDING_RESPONSE);
            if (merged != stxma_pkg::BINDING_RESPONSE) begin
              phase_d = stxma_pkg::PH_DONE;
            end
          end
          if (phase_d == stxma_pkg::PH_HEADER && idx_q == IdxW'(19)) begin
            phase_d = stxma_pkg::PH_ATTR_HDR;
            rem_d   = stxma_pkg::ATTR_HDR_BYTES;
            atype_d = '0;
            alen_d  = '0;
          end
        end
        stxma_pkg::PH_ATTR_HDR: begin
          if (rem_q >= 17'd3) begin
            atype_d = {atype_q[7:0], step_i.data_byte};
          end else begin
            alen_d = {alen_q[7:0], step_i.data_byte};
          end
          rem_d = rem_q - 17'd1;
          if (rem_q == 17'd1) begin
            if (atype_d == stxma_pkg::XOR_ADDR_ATTR) begin
              phase_d = stxma_pkg::PH_ADDR;
              rem_d   = stxma_pkg::ADDR_BYTES;
              port_d  = '0;
              addr_d  = '0;
            end else begin
              padded = ({1'b0, alen_d} + 17'd3) & 17'h1FFFC;
              if (padded == 17'd0) begin
                // empty value: next attribute header straight away
                phase_d = stxma_pkg::PH_ATTR_HDR;
                rem_d   = stxma_pkg::ATTR_HDR_BYTES;
                atype_d = '0;
                alen_d  = '0;
              end else begin
                phase_d = stxma_pkg::PH_SKIP;
                rem_d   = padded;
              end
            end
          end
        end
        stxma_pkg::PH_SKIP: begin
          rem_d = rem_q - 17'd1;
          if (rem_q == 17'd1) begin
            phase_d = stxma_pkg::PH_ATTR_HDR;
            rem_d   = stxma_pkg::ATTR_HDR_BYTES;
            atype_d = '0;
            alen_d  = '0;
          end
        end
        stxma_pkg::PH_ADDR: begin
          // reserved and family first, then port, then address
          if (rem_q == 17'd6 || rem_q == 17'd5) begin
            port_d = {port_q[7:0], step_i.data_byte};
          end else if (rem_q <= 17'd4) begin
            addr_d = {addr_q[23:0], step_i.data_byte};
          end
          rem_d = rem_q - 17'd1;
          if (rem_q == 17'd1) begin
            found_d = 1'b1;
            phase_d = stxma_pkg::PH_DONE;
          end
        end
        stxma_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    if (idx_d < IdxW'(2) || !match_d) begin
      result_o.status = stxma_pkg::ST_BAD_TYPE;
    end else if (found_d) begin
      result_o.status         = stxma_pkg::ST_FOUND;
      result_o.public_address = addr_d ^ stxma_pkg::XOR_COOKIE;
      result_o.mapped_port    = port_d ^ stxma_pkg::PORT_MASK;
    end

    // Back to the start for the next datagram
    if (step_i.last_byte) begin
      idx_d   = '0;
      phase_d = stxma_pkg::PH_HEADER;
      match_d = 1'b0;
      atype_d = '0;
      alen_d  = '0;
      rem_d   = '0;
      port_d  = '0;
      addr_d  = '0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      phase_q <= stxma_pkg::PH_HEADER;
      match_q <= 1'b0;
      atype_q <= '0;
      alen_q  <= '0;
      rem_q   <= '0;
      port_q  <= '0;
      addr_q  <= '0;
      found_q <= 1'b0;
    end else if (step_i.fire) begin
      idx_q   <= idx_d;
      phase_q <= phase_d;
      match_q <= match_d;
      atype_q <= atype_d;
      alen_q  <= alen_d;
      rem_q   <= rem_d;
      port_q  <= port_d;
      addr_q  <= addr_d;
      found_q <= found_d;
    end
  end

endmodule

/* hdl/stxma_out_stage.sv */
// Result register: holds one decoded result until the sink takes it.
module stxma_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  stxma_pkg::result_t  result_i,
  output logic                free_o,
  stxma_out_if.source         out_o
);

  logic                valid_q;
  stxma_pkg::result_t  res_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.public_address = res_q.public_address;
  assign out_o.mapped_port    = res_q.mapped_port;

endmodule

/* hdl/stun_xor_mapped_address_parser_core.sv */
// Top level of the STUN binding-response XOR-MAPPED-ADDRESS parser.
//
//   channel | dir | payload                                  | transfer
//   in_i    | in  | data_byte[7:0], last_byte                | one datagram byte
//   out_o   | out | status[1:0], public_address[31:0],       | one result per
//           |     | mapped_port[15:0]                        | datagram
//
// One byte per cycle while the result slot is free; a byte passes the input
// register, then the parse logic, and a result is loaded into the result
// register as its final byte leaves the input register, once the slot is free.
// Reset clears the input, parse and result state; the first byte may follow.
// A pending result stalls the next final byte and all input behind it.
module stun_xor_mapped_address_parser_core #(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stxma_in_if.sink    in_i,
  stxma_out_if.source out_o
);

  stxma_pkg::step_t   step;
  stxma_pkg::result_t result;
  logic               out_free;

  stxma_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .step_o     (step)
  );

  stxma_parser #(
    .MAX_BYTES (MAX_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .result_o (result)
  );

  stxma_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step.fire && step.last_byte),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule

/* hdl/stxma_checker.sv */
// Port-level assertions for the parser core, bound to the top level.
module stxma_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [31:0] out_address_i,
  input logic [15:0] out_port_i
);

  // Input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == stxma_pkg::ST_FOUND ||
                     out_status_i == stxma_pkg::ST_BAD_TYPE ||
                     out_status_i == stxma_pkg::ST_NO_ADDR))
    else $error("undefined status code");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_status_i != stxma_pkg::ST_FOUND) |->
      (out_address_i == 32'd0 && out_port_i == 16'd0))
    else $error("address or port set on a failed decode");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_status_i) &&
       $stable(out_address_i) && $stable(out_port_i)))
    else $error("stalled result changed");

endmodule

bind stun_xor_mapped_address_parser_core stxma_checker u_stxma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_address_i (out_o.public_address),
  .out_port_i    (out_o.mapped_port)
);
